// File: src/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter block.
// Holds the channel payload structs, sequencer states and CSR map.
// No dependencies; imported by every module of the block.
package skf_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int NOISE_W    = 24;

   // CSR word indexes (byte address = 4 * index)
   localparam logic [2:0] REG_TEMP_Q = 3'd0;
   localparam logic [2:0] REG_TEMP_R = 3'd1;
   localparam logic [2:0] REG_HUM_Q  = 3'd2;
   localparam logic [2:0] REG_HUM_R  = 3'd3;
   localparam logic [2:0] REG_VOC_Q  = 3'd4;
   localparam logic [2:0] REG_VOC_R  = 3'd5;

   localparam logic [NOISE_W-1:0] TEMP_Q_RST = 24'd5243;
   localparam logic [NOISE_W-1:0] TEMP_R_RST = 24'd49152;
   localparam logic [NOISE_W-1:0] HUM_Q_RST  = 24'd7864;
   localparam logic [NOISE_W-1:0] HUM_R_RST  = 24'd78643;
   localparam logic [NOISE_W-1:0] VOC_Q_RST  = 24'd262144;
   localparam logic [NOISE_W-1:0] VOC_R_RST  = 24'd1572864;

   // Channel codes
   localparam logic [1:0] CHAN_TEMP = 2'd0;
   localparam logic [1:0] CHAN_HUM  = 2'd1;

   typedef struct packed {
      logic [1:0]         channel;
      logic signed [31:0] measurement;
      logic               restart;
   } skf_req_type;

   typedef struct packed {
      logic [1:0]         out_channel;
      logic signed [31:0] estimate;
      logic signed [15:0] estimate_rounded;
      logic               was_first;
   } skf_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_SUM,
      ST_DIV,
      ST_MUL_EST,
      ST_UPD_EST,
      ST_UPD_COV,
      ST_ROUND,
      ST_DONE
   } skf_state_type;

endpackage

// File: src/skf_div.sv
// Restoring divider for the filter gain: quotient = (dividend << FRAC_BITS) / divisor.
// Requires dividend <= divisor; one quotient bit per cycle. Uses skf_pkg.
module skf_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          dividend,
   input  logic [32:0]          divisor,
   output logic [FRAC_BITS:0]   quotient,
   output logic                 done
);
   import skf_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic [32:0]        rem_ff, rem_in;
   logic [32:0]        div_ff;
   logic [FRAC_BITS:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   logic [33:0]        shifted;
   logic               step_ge;
   logic               first_ge;

   assign first_ge = {1'b0, dividend} >= divisor;
   assign shifted  = {rem_ff, 1'b0};
   assign step_ge  = shifted >= {1'b0, div_ff};

   always_comb begin
      if (start) begin
         rem_in = first_ge ? ({1'b0, dividend} - divisor) : {1'b0, dividend};
         quo_in = {{FRAC_BITS{1'b0}}, first_ge};
      end else begin
         rem_in = step_ge ? 33'(shifted - {1'b0, div_ff}) : shifted[32:0];
         quo_in = {quo_ff[FRAC_BITS-1:0], step_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(FRAC_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
      end
      if (start || busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: src/scalar_kalman_filter.sv
// Scalar Kalman filter, one 1-D filter per sensor channel, Q16.16 by default.
// States: first sample or unused channel PREDICT, ROUND, DONE; a filter update adds
//   SUM, DIV (bit-per-cycle gain divider), MUL_EST, UPD_EST, UPD_COV before ROUND.
// Throughput: one item at a time; req_stall stays high until the result is queued.
// Reset: synchronous; clears all channels to uninitialized, loads default noise regs.
module scalar_kalman_filter #(
   parameter int CHANNELS  = 3,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  skf_pkg::skf_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output skf_pkg::skf_rsp_type               rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [skf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [skf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [skf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import skf_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int GAIN_W = FRAC_BITS + 1;
   localparam int PROD_W = FRAC_BITS + 36;

   localparam logic [3:0]               CHAN_LIMIT = 4'(CHANNELS);
   localparam logic [GAIN_W-1:0]        GAIN_ONE   = GAIN_W'(1) << FRAC_BITS;
   localparam logic signed [PROD_W-1:0] HALF_P     = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [33:0]       HALF_R     = 34'(1) << (FRAC_BITS - 1);
   localparam logic signed [33:0]       TRUNC_BIAS = (34'(1) << FRAC_BITS) - 34'(1);

   // ---------------------------------------------------------------------------
   // Noise registers (APB). Writes land on the access phase; pready tied high.
   // ---------------------------------------------------------------------------
   logic [NOISE_W-1:0] temp_q_ff, temp_r_ff, hum_q_ff, hum_r_ff, voc_q_ff, voc_r_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_q_ff <= TEMP_Q_RST;
         temp_r_ff <= TEMP_R_RST;
         hum_q_ff  <= HUM_Q_RST;
         hum_r_ff  <= HUM_R_RST;
         voc_q_ff  <= VOC_Q_RST;
         voc_r_ff  <= VOC_R_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TEMP_Q: temp_q_ff <= pwdata[NOISE_W-1:0];
            REG_TEMP_R: temp_r_ff <= pwdata[NOISE_W-1:0];
            REG_HUM_Q:  hum_q_ff  <= pwdata[NOISE_W-1:0];
            REG_HUM_R:  hum_r_ff  <= pwdata[NOISE_W-1:0];
            REG_VOC_Q:  voc_q_ff  <= pwdata[NOISE_W-1:0];
            REG_VOC_R:  voc_r_ff  <= pwdata[NOISE_W-1:0];
            default: ;  // unmapped word: drop the write
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TEMP_Q: prdata = {8'd0, temp_q_ff};
         REG_TEMP_R: prdata = {8'd0, temp_r_ff};
         REG_HUM_Q:  prdata = {8'd0, hum_q_ff};
         REG_HUM_R:  prdata = {8'd0, hum_r_ff};
         REG_VOC_Q:  prdata = {8'd0, voc_q_ff};
         REG_VOC_R:  prdata = {8'd0, voc_r_ff};
         default:    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Channel state and captured item
   // ---------------------------------------------------------------------------
   skf_state_type      state_ff, state_in;
   skf_req_type        item_ff;
   logic [CHANNELS-1:0] started_ff;
   logic signed [31:0] est_mem_ff [CHANNELS];
   logic [31:0]        cov_mem_ff [CHANNELS];

   logic               req_xfer;
   logic [CH_W-1:0]    ch_idx;
   logic               in_range;
   logic               ch_started;
   logic               init_chan;
   logic [NOISE_W-1:0] q_sel, r_sel;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign ch_idx    = CH_W'(item_ff.channel);
   assign in_range  = {2'b00, item_ff.channel} < CHAN_LIMIT;
   assign ch_started = in_range && started_ff[ch_idx];
   assign init_chan = (state_ff == ST_PREDICT) && in_range && !ch_started;

   // Channels past the three register pairs share the air-quality pair.
   always_comb begin
      unique case (item_ff.channel)
         CHAN_TEMP: begin
            q_sel = temp_q_ff;
            r_sel = temp_r_ff;
         end
         CHAN_HUM: begin
            q_sel = hum_q_ff;
            r_sel = hum_r_ff;
         end
         default: begin
            q_sel = voc_q_ff;
            r_sel = voc_r_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------------------
   logic [31:0]             p_ff;
   logic signed [31:0]      x_ff;
   logic signed [32:0]      diff_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic                    dzero_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [31:0]      est_ff;
   logic                    first_ff;
   logic signed [15:0]      rounded_ff;
   logic                    rsp_valid_ff;
   skf_rsp_type             rsp_data_ff;

   // Predict: P + Q with saturation, innovation z - x.
   logic [32:0]        p_sum;
   logic signed [31:0] x_cur;
   logic signed [32:0] diff_cur;

   assign x_cur    = est_mem_ff[ch_idx];
   assign p_sum    = {1'b0, cov_mem_ff[ch_idx]} + 33'(q_sel);
   assign diff_cur = {item_ff.measurement[31], item_ff.measurement} - {x_cur[31], x_cur};

   // Gain denominator P + R feeds the divider on its start cycle.
   logic [32:0]       d_sum;
   logic              div_start;
   logic [GAIN_W-1:0] div_quo;
   logic              div_done;

   assign d_sum     = {1'b0, p_ff} + 33'(r_sel);
   assign div_start = (state_ff == ST_SUM);

   skf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (p_ff),
      .divisor  (d_sum),
      .quotient (div_quo),
      .done     (div_done)
   );

   // Shared multiplier: K * (z - x) first, then (1 - K) * P.
   logic [GAIN_W-1:0]        mul_a;
   logic signed [33:0]       mul_b;
   logic signed [PROD_W-1:0] mul_out;

   always_comb begin
      if (state_ff == ST_MUL_EST) begin
         mul_a = gain_ff;
         mul_b = {diff_ff[32], diff_ff};
      end else begin
         mul_a = GAIN_ONE - gain_ff;
         mul_b = {2'b00, p_ff};
      end
   end

   assign mul_out = $signed({1'b0, mul_a}) * mul_b;

   // Estimate step: round the product to nearest, add, clamp to 32 bits.
   logic signed [PROD_W-1:0] est_rnd;
   logic signed [PROD_W-1:0] est_delta;
   logic signed [35:0]       est_next;
   logic signed [31:0]       est_sat;

   assign est_rnd   = prod_ff + HALF_P;
   assign est_delta = est_rnd >>> FRAC_BITS;
   assign est_next  = {{4{x_ff[31]}}, x_ff} + est_delta[35:0];

   always_comb begin
      if ((est_next[35:31] == 5'b00000) || (est_next[35:31] == 5'b11111)) begin
         est_sat = est_next[31:0];
      end else if (est_next[35]) begin
         est_sat = 32'sh8000_0000;
      end else begin
         est_sat = 32'sh7fff_ffff;
      end
   end

   // Covariance step: product is never negative; result fits 32 bits.
   logic [PROD_W-1:0] cov_rnd;
   logic [31:0]       cov_next;

   assign cov_rnd  = prod_ff + HALF_P;
   assign cov_next = cov_rnd[FRAC_BITS +: 32];

   // Rounded integer: add one half, truncate toward zero, clamp to 16 bits.
   logic signed [33:0] rnd_sum;
   logic signed [33:0] rnd_adj;
   logic signed [33:0] rnd_int;
   logic signed [15:0] rnd_sat;

   assign rnd_sum = {{2{est_ff[31]}}, est_ff} + HALF_R;
   assign rnd_adj = rnd_sum[33] ? (rnd_sum + TRUNC_BIAS) : rnd_sum;
   assign rnd_int = rnd_adj >>> FRAC_BITS;

   always_comb begin
      if ((rnd_int[33:15] == '0) || (rnd_int[33:15] == '1)) begin
         rnd_sat = rnd_int[15:0];
      end else if (rnd_int[33]) begin
         rnd_sat = 16'sh8000;
      end else begin
         rnd_sat = 16'sh7fff;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_PREDICT;
            end
         end
         ST_PREDICT: begin
            // first sample or unused channel: no filter step
            if (!ch_started) begin
               state_in = ST_ROUND;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:     state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL_EST;
            end
         end
         ST_MUL_EST: state_in = ST_UPD_EST;
         ST_UPD_EST: state_in = ST_UPD_COV;
         ST_UPD_COV: state_in = ST_ROUND;
         ST_ROUND:   state_in = ST_DONE;
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Started flags: restart clears every channel before the sample applies.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= '0;
      end else if (req_xfer && req_data.restart) begin
         started_ff <= '0;
      end else if (init_chan) begin
         started_ff[ch_idx] <= 1'b1;
      end
   end

   // Per-channel estimate and covariance, one write per cycle.
   always_ff @(posedge clock) begin
      if (init_chan) begin
         est_mem_ff[ch_idx] <= item_ff.measurement;
         cov_mem_ff[ch_idx] <= 32'(r_sel);
      end else if (state_ff == ST_UPD_COV) begin
         est_mem_ff[ch_idx] <= est_ff;
         cov_mem_ff[ch_idx] <= cov_next;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_PREDICT) begin
         p_ff     <= p_sum[32] ? 32'hffff_ffff : p_sum[31:0];
         x_ff     <= x_cur;
         diff_ff  <= diff_cur;
         est_ff   <= in_range ? item_ff.measurement : 32'sd0;
         first_ff <= in_range && !ch_started;
      end
      if (state_ff == ST_SUM) begin
         dzero_ff <= (d_sum == 33'd0);
      end
      if ((state_ff == ST_DIV) && div_done) begin
         // zero denominator: gain 0, estimate and covariance hold
         gain_ff <= dzero_ff ? '0 : div_quo;
      end
      if ((state_ff == ST_MUL_EST) || (state_ff == ST_UPD_EST)) begin
         prod_ff <= mul_out;
      end
      if (state_ff == ST_UPD_EST) begin
         est_ff <= est_sat;
      end
      if (state_ff == ST_ROUND) begin
         rounded_ff <= rnd_sat;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff.out_channel      <= item_ff.channel;
         rsp_data_ff.estimate         <= est_ff;
         rsp_data_ff.estimate_rounded <= rounded_ff;
         rsp_data_ff.was_first        <= first_ff;
      end
   end

   // Output register: load on DONE, drop once the result transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/skf_checker.sv
// Port-level checks for scalar_kalman_filter, bound to the top level.
// Depends on skf_pkg for the result payload type.
module skf_port_checks #(
   parameter int CHANNELS = 3
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input skf_pkg::skf_rsp_type rsp_data
);
   import skf_pkg::*;

   // no result is pending right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // an accepted item blocks the input and cannot produce a result at once
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !$rose(rsp_valid))
      else $error("item accepted while busy or result too early");

   // an unused channel reports a zero estimate and never initializes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (int'(rsp_data.out_channel) >= CHANNELS) |->
         (rsp_data.estimate == 32'sd0) && !rsp_data.was_first)
      else $error("unused channel reported state");

endmodule

bind scalar_kalman_filter skf_port_checks #(
   .CHANNELS (CHANNELS)
) u_skf_port_checks (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/skf_checker.sv
// Checker for the scalar Kalman filter: tracks the noise registers from the CSR port,
// predicts every estimate from the accepted samples and compares the results.
// Depends on skf_pkg for the payload structs, register indexes and reset values.
module skf_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  skf_pkg::skf_req_type           req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  skf_pkg::skf_rsp_type           rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [skf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [skf_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             fail_count,
   output int                             outstanding
);
   import skf_pkg::*;

   localparam int          FILTERS = 3;
   localparam int          FRAC    = 16;
   localparam logic [63:0] ONE_U   = 64'd1 << FRAC;
   localparam logic [63:0] HALF_U  = 64'd1 << (FRAC - 1);
   localparam longint      ONE_S   = 64'sd1 << FRAC;
   localparam longint      HALF_S  = 64'sd1 << (FRAC - 1);
   localparam logic [63:0] COV_MAX = 64'hFFFF_FFFF;
   localparam longint      EST_MAX = 2147483647;
   localparam longint      EST_MIN = -EST_MAX - 1;
   localparam longint      RND_MAX = 32767;
   localparam longint      RND_MIN = -32768;

   logic [NOISE_W-1:0] noise [0:5];
   logic signed [31:0] est_q [0:FILTERS-1];
   logic [31:0]        cov_q [0:FILTERS-1];
   logic               seen  [0:FILTERS-1];
   skf_rsp_type        pending_estimates [$];

   function automatic void forget_channels();
      for (int c = 0; c < FILTERS; c++) begin
         est_q[c] = '0;
         cov_q[c] = ONE_U[31:0];
         seen[c]  = 1'b0;
      end
   endfunction

   // Advance one filter by one sample and return the estimate it should report.
   function automatic skf_rsp_type filter_step(skf_req_type s);
      skf_rsp_type o;
      int          c;
      logic [63:0] q, r, p, d, g;
      longint      x, meas, prod, nx, rnd;
      o = '0;
      c = s.channel;
      nx = 0;
      if (s.restart)
         forget_channels();
      o.out_channel = s.channel;
      if (c < FILTERS) begin
         q = noise[REG_TEMP_Q + 2 * c];
         r = noise[REG_TEMP_R + 2 * c];
         if (!seen[c]) begin
            est_q[c] = s.measurement;
            cov_q[c] = r[31:0];
            seen[c] = 1'b1;
            o.was_first = 1'b1;
         end else begin
            p = cov_q[c] + q;
            if (p > COV_MAX)
               p = COV_MAX;
            d = p + r;
            g = (d != 0) ? (p << FRAC) / d : 64'd0;
            x = est_q[c];
            meas = $signed(s.measurement);
            prod = longint'(g) * (meas - x) + HALF_S;
            nx = x + (prod >>> FRAC);
            if (nx > EST_MAX)
               nx = EST_MAX;
            if (nx < EST_MIN)
               nx = EST_MIN;
            est_q[c] = nx[31:0];
            cov_q[c] = 32'((((ONE_U - g) * p) + HALF_U) >> FRAC);
         end
         nx = est_q[c];
      end
      // truncating divide: rounds half up, then toward zero
      rnd = (nx + HALF_S) / ONE_S;
      if (rnd > RND_MAX)
         rnd = RND_MAX;
      if (rnd < RND_MIN)
         rnd = RND_MIN;
      o.estimate = nx[31:0];
      o.estimate_rounded = rnd[15:0];
      return o;
   endfunction

   task automatic flag_mismatch(string what, longint got, longint want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      skf_rsp_type want;
      if (reset) begin
         noise[REG_TEMP_Q] = TEMP_Q_RST;
         noise[REG_TEMP_R] = TEMP_R_RST;
         noise[REG_HUM_Q]  = HUM_Q_RST;
         noise[REG_HUM_R]  = HUM_R_RST;
         noise[REG_VOC_Q]  = VOC_Q_RST;
         noise[REG_VOC_R]  = VOC_R_RST;
         forget_channels();
         pending_estimates.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_estimates.size() == 0) begin
               flag_mismatch("unexpected result, channel", rsp_data.out_channel, -1);
            end else begin
               want = pending_estimates.pop_front();
               if (rsp_data.out_channel !== want.out_channel)
                  flag_mismatch("out_channel", rsp_data.out_channel, want.out_channel);
               if (rsp_data.estimate !== want.estimate)
                  flag_mismatch("estimate", $signed(rsp_data.estimate),
                                $signed(want.estimate));
               if (rsp_data.estimate_rounded !== want.estimate_rounded)
                  flag_mismatch("estimate_rounded", $signed(rsp_data.estimate_rounded),
                                $signed(want.estimate_rounded));
               if (rsp_data.was_first !== want.was_first)
                  flag_mismatch("was_first", rsp_data.was_first, want.was_first);
            end
         end
         if (req_valid && !req_stall)
            pending_estimates.push_back(filter_step(req_data));
         if (psel && penable && pwrite && pready && paddr[CSR_ADDR_W-1:2] <= REG_VOC_R)
            noise[paddr[CSR_ADDR_W-1:2]] = pwdata[NOISE_W-1:0];
      end
      outstanding <= pending_estimates.size();
   end

endmodule

// File: tb/scalar_kalman_filter_test.sv
// Top of the scalar Kalman filter testbench: clock, reset, sample stimulus, CSR
// writes, random idling on both channels and the final verdict.
// Depends on skf_pkg, scalar_kalman_filter and skf_checker.
module scalar_kalman_filter_test;
   import skf_pkg::*;

   // channel codes the package leaves out
   localparam logic [1:0] CHAN_VOC  = 2'd2;
   localparam logic [1:0] CHAN_NONE = 2'd3;
   // word indexes past the register map; writes there must be dropped
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam logic [23:0] NOISE_MAX   = 24'hFF_FFFF;
   localparam int          IDLE_LIMIT  = 2000;
   localparam int          TAIL_CYCLES = 40;
   localparam int          PHASES      = 5;
   localparam int          PHASE_ITEMS = 120;
   localparam int          ONE_FX      = 65536;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   skf_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   skf_rsp_type           rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int outstanding;
   int idle_cycles = 0;
   int stall_run   = 0;
   bit gaps_on     = 1'b1;
   bit stalls_on   = 1'b0;

   scalar_kalman_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   skf_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   // Receiver stalls: random runs, each drawn as stall one time in three and as flow otherwise.
   always @(posedge clock) begin
      if (reset || !stalls_on) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run == 0) begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_run = $urandom_range(1, 16) - 1;
      end else begin
         stall_run--;
      end
   end

   // Watchdog: count cycles with no transfer on any port; give up at the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Setup then access phase; the register takes the value at the access edge.
   // Fill the unused upper byte with noise, the block keeps only 24 bits.
   // Leave the bus idle before returning.
   task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {8'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Load all six noise registers, plus the two spare words that must be ignored.
   task automatic load_noise(input logic [23:0] tq, tr, hq, hr, vq, vr);
      write_reg(REG_TEMP_Q, tq);
      write_reg(REG_TEMP_R, tr);
      write_reg(REG_HUM_Q, hq);
      write_reg(REG_SPARE_LO, 24'($urandom));
      write_reg(REG_HUM_R, hr);
      write_reg(REG_VOC_Q, vq);
      write_reg(REG_VOC_R, vr);
      write_reg(REG_SPARE_HI, 24'($urandom));
   endtask

   // Present one sample and hold it until the transfer; keep valid up when the
   // next sample follows at once. A pause always drops valid before the next sample.
   task automatic send_sample(input logic [1:0] ch, input logic [31:0] meas,
                              input logic rst, input bit pause_after);
      int gap;
      gap = 0;
      req_data  <= '{channel: ch, measurement: meas, restart: rst};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 16);
      if (pause_after && gap == 0)
         gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every predicted estimate has come back.
   task automatic drain();
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [1:0]  ch;
      logic [31:0] meas;
      logic        rst;
      int          pick;
      repeat (6) @(posedge clock);
      reset     <= 1'b0;
      stalls_on <= 1'b1;

      // Directed samples on the reset register values: range extremes, rounding
      // ties, the unused channel and restarts.
      send_sample(CHAN_TEMP, 32'h7FFF_FFFF, 1'b0, 1'b0);  // first, rounded saturates high
      send_sample(CHAN_TEMP, 32'h8000_0000, 1'b0, 1'b0);  // full-scale swing
      send_sample(CHAN_HUM, 32'h8000_0000, 1'b0, 1'b0);   // first, -32768.0 rounds to -32767
      send_sample(CHAN_HUM, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_sample(CHAN_VOC, 32'h0, 1'b0, 1'b0);
      send_sample(CHAN_VOC, 25 * ONE_FX, 1'b0, 1'b0);
      send_sample(CHAN_NONE, 32'h1234_5678, 1'b0, 1'b0);  // no such filter
      send_sample(CHAN_NONE, 32'hFFFF_FFFF, 1'b1, 1'b0);  // restart from the unused channel
      send_sample(CHAN_TEMP, 32'h0000_8000, 1'b0, 1'b0);  // +0.5 rounds up
      send_sample(CHAN_HUM, -32'sh8000, 1'b0, 1'b0);      // -0.5 rounds to zero
      send_sample(CHAN_VOC, -32'sh1_8000, 1'b0, 1'b0);    // -1.5 rounds to -1
      send_sample(CHAN_TEMP, 32'h0000_7FFF, 1'b0, 1'b0);
      send_sample(CHAN_HUM, 32'h0001_8000, 1'b1, 1'b0);   // restart on a live channel
      send_sample(CHAN_HUM, 32'hFFFF_FFFF, 1'b0, 1'b1);
      drain();

      // All noise zero: covariance starts at zero, so P + R is zero and the
      // estimate must hold.
      load_noise(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      send_sample(CHAN_TEMP, 100 * ONE_FX, 1'b1, 1'b0);
      send_sample(CHAN_TEMP, -100 * ONE_FX, 1'b0, 1'b0);
      send_sample(CHAN_VOC, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_sample(CHAN_VOC, 32'h8000_0000, 1'b0, 1'b1);
      drain();

      // All noise at full scale.
      load_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX, NOISE_MAX, NOISE_MAX, NOISE_MAX);
      send_sample(CHAN_HUM, 32'h7FFF_FFFF, 1'b1, 1'b0);
      send_sample(CHAN_HUM, 32'h8000_0000, 1'b0, 1'b0);
      send_sample(CHAN_HUM, 32'h0, 1'b0, 1'b0);
      send_sample(CHAN_TEMP, 32'h8000_0000, 1'b0, 1'b0);
      send_sample(CHAN_TEMP, 32'h7FFF_FFFF, 1'b0, 1'b1);
      drain();

      // Random phases, each on its own register setting.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               load_noise(TEMP_Q_RST, TEMP_R_RST, HUM_Q_RST, HUM_R_RST, VOC_Q_RST,
                          VOC_R_RST);
            end
            2: begin
               // lopsided: one channel trusts the sensor, one ignores it
               load_noise(24'd0, NOISE_MAX, NOISE_MAX, 24'd0,
                          24'($urandom), 24'($urandom));
            end
            3: begin
               load_noise(24'($urandom_range(0, ONE_FX * 16)),
                          24'($urandom_range(0, ONE_FX * 16)),
                          24'($urandom_range(0, ONE_FX * 16)),
                          24'($urandom_range(0, ONE_FX * 16)),
                          24'($urandom_range(0, ONE_FX * 16)),
                          24'($urandom_range(0, ONE_FX * 16)));
            end
            default: begin
               load_noise(24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom), 24'($urandom));
            end
         endcase
         // last phase runs flat out with no random idling on either side
         if (ph == PHASES - 1) begin
            gaps_on = 1'b0;
            stalls_on <= 1'b0;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // a quiet stretch in the middle of the second phase
            if (ph == 1 && k == 60) begin
               gaps_on = 1'b0;
               stalls_on <= 1'b0;
            end else if (ph == 1 && k == 90) begin
               gaps_on = 1'b1;
               stalls_on <= 1'b1;
            end
            pick = $urandom_range(0, 19);
            ch = (pick < 2) ? CHAN_NONE : 2'($urandom_range(0, 2));
            rst = ($urandom_range(0, 39) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               meas = $urandom;
            end else if (pick == 1) begin
               case ($urandom_range(0, 3))
                  0: meas = 32'h7FFF_FFFF;
                  1: meas = 32'h8000_0000;
                  2: meas = 32'h0;
                  default: meas = 32'hFFFF_FFFF;
               endcase
            end else begin
               // plausible readings within +/-64.0 keep the filters tracking
               meas = int'($urandom_range(0, 128 * ONE_FX)) - 64 * ONE_FX;
            end
            send_sample(ch, meas, rst, (k % 40 == 39) || (k == PHASE_ITEMS - 1));
            if (k % 40 == 39)
               drain();
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
